// ===== design/avte_pkg.sv =====
// Shared types, constants and helper functions for the vertex transform engine.
`default_nettype none
package avte_pkg;
	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	// Accumulator width: four rounded 33x32 products summed without wrap.
	localparam int ACC_W = 2 * W - FRAC_BITS + 3;
	localparam logic signed [W-1:0] ONE_Q = W'(1) <<< FRAC_BITS;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	localparam logic [2:0] OP_IDENT = 3'd0;
	localparam logic [2:0] OP_TRANS = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_ROTX  = 3'd3;
	localparam logic [2:0] OP_ROTY  = 3'd4;
	localparam logic [2:0] OP_ROTZ  = 3'd5;
	localparam logic [2:0] OP_VERT  = 3'd6;
	localparam logic [2:0] OP_RSVD  = 3'd7;

	localparam logic CFG_PERSP = 1'b0;
	localparam logic CFG_CZ    = 1'b1;

	typedef struct packed {
		logic [2:0]          opcode;
		logic signed [W-1:0] arg_a;
		logic signed [W-1:0] arg_b;
		logic signed [W-1:0] arg_c;
	} cmd_t;

	typedef struct packed {
		logic signed [W-1:0] out_x;
		logic signed [W-1:0] out_y;
		logic signed [W-1:0] out_z;
		logic                divide_error;
	} res_t;

	typedef struct packed {
		logic      [0:0]     index;
		logic      [W-1:0]   data;
	} cfg_t;

	// Elementary matrix element (row i, col k), 33-bit signed.
	function automatic logic signed [W:0] elem(input logic [2:0] op,
			input logic signed [W-1:0] a, input logic signed [W-1:0] b,
			input logic signed [W-1:0] c, input logic [1:0] i, input logic [1:0] k);
		logic signed [W:0] one, ea, eb, ec, nb, r;
		one = (W+1)'(ONE_Q);
		ea = {a[W-1], a};
		eb = {b[W-1], b};
		ec = {c[W-1], c};
		nb = -eb;
		r = (i == k) ? one : '0;
		case (op)
			OP_TRANS: begin
				if (k == 2'd3 && i == 2'd0) r = ea;
				if (k == 2'd3 && i == 2'd1) r = eb;
				if (k == 2'd3 && i == 2'd2) r = ec;
			end
			OP_SCALE: begin
				if (i == k && i == 2'd0) r = ea;
				if (i == k && i == 2'd1) r = eb;
				if (i == k && i == 2'd2) r = ec;
			end
			OP_ROTX: begin
				if (i == 2'd1 && k == 2'd1) r = ea;
				if (i == 2'd1 && k == 2'd2) r = nb;
				if (i == 2'd2 && k == 2'd1) r = eb;
				if (i == 2'd2 && k == 2'd2) r = ea;
			end
			OP_ROTY: begin
				if (i == 2'd0 && k == 2'd0) r = ea;
				if (i == 2'd0 && k == 2'd2) r = eb;
				if (i == 2'd2 && k == 2'd0) r = nb;
				if (i == 2'd2 && k == 2'd2) r = ea;
			end
			OP_ROTZ: begin
				if (i == 2'd0 && k == 2'd0) r = ea;
				if (i == 2'd0 && k == 2'd1) r = nb;
				if (i == 2'd1 && k == 2'd0) r = eb;
				if (i == 2'd1 && k == 2'd1) r = ea;
			end
			default: r = r;
		endcase
		return r;
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [ACC_W-1:0] v);
		if (v > (ACC_W)'(SMAX)) return SMAX;
		if (v < (ACC_W)'(SMIN)) return SMIN;
		return v[W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/avte_if.sv =====
// Valid/ready channel interfaces for commands, results and configuration.
`default_nettype none
interface avte_cmd_if;
	logic              valid;
	logic              ready;
	avte_pkg::cmd_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface avte_res_if;
	logic              valid;
	logic              ready;
	avte_pkg::res_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface avte_cfg_if;
	logic              valid;
	logic              ready;
	avte_pkg::cfg_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/avte_mac.sv =====
// Shared multiply, round and accumulate unit: 33x32 product, rounded, summed.
`default_nettype none
module avte_mac (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           clr,
	input  wire logic signed [avte_pkg::W:0]    a,
	input  wire logic signed [avte_pkg::W-1:0]  b,
	output logic signed [avte_pkg::ACC_W-1:0]   acc
);
	localparam int PW = 2 * avte_pkg::W + 1;
	logic signed [PW-1:0] prod_s1;
	logic                 en_s1, clr_s1;
	logic signed [PW-1:0] rnd;
	logic signed [avte_pkg::ACC_W-1:0] term;

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			clr_s1 <= 1'b0;
		end else begin
			en_s1 <= en;
			clr_s1 <= clr;
		end
	end

	always_comb begin
		rnd = (prod_s1 + (PW'(1) <<< (avte_pkg::FRAC_BITS - 1))) >>> avte_pkg::FRAC_BITS;
		term = rnd[avte_pkg::ACC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			acc <= clr_s1 ? term : acc + term;
		end
	end
endmodule
`default_nettype wire

// ===== design/avte_div.sv =====
// Radix-2 restoring signed divider, quotient truncated toward zero.
`default_nettype none
module avte_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [64:0]   num,
	input  wire logic signed [33:0]   den,
	output logic                      done,
	output logic signed [65:0]        quo
);
	logic [64:0] n_q, q_q;
	logic [33:0] d_q;
	logic [34:0] r_q;
	logic        neg_q, busy_q;
	logic [6:0]  cnt_q;
	logic [34:0] sh, sub;

	always_comb begin
		sh = {r_q[33:0], n_q[64]};
		sub = sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd65;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[64] ? -num : num;
			d_q <= den[33] ? -den : den;
			neg_q <= num[64] ^ den[33];
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[63:0], 1'b0};
			if (!sub[34]) begin
				r_q <= sub;
				q_q <= {q_q[63:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[63:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -{1'b0, q_q} : {1'b0, q_q};
endmodule
`default_nettype wire

// ===== design/affine_vertex_transform_engine.sv =====
// Top level: matrix memory, sequencer, shared MAC and perspective divider.
// Identity rewrites the matrix in a sweep; matrix ops run the MAC over all 16 elements,
// then copy scratch to matrix; a vertex runs three rows, with perspective two divides after.
// One transaction in flight; the shared MAC and the divider set the rate, and the
// result register lets the next transaction start while a result waits.
// Reset: asynchronous; control registers clear and a sweep writes identity to all 16 elements.
`default_nettype none
module affine_vertex_transform_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	avte_cmd_if.sink  cmd,
	avte_res_if.source res,
	avte_cfg_if.sink  cfg
);
	localparam int W = avte_pkg::W;

	// Sequencer states
	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ISSUE = 4'd2;
	localparam logic [3:0] ST_DRAIN = 4'd3;
	localparam logic [3:0] ST_WB    = 4'd4;
	localparam logic [3:0] ST_COPY  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_DWAIT = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] st_q;

	logic signed [avte_pkg::ACC_W-1:0] acc;
	logic signed [W-1:0] sat_acc;

	// Two memories: live matrix and scratch for E*M. Sync read: read data is registered.
	logic signed [W-1:0] mat_mem [16];
	logic signed [W-1:0] tmp_mem [16];
	logic [3:0]          mat_ra, mat_wa, tmp_wa, tmp_ra;
	logic                mat_we, tmp_we;
	logic signed [W-1:0] mat_wd, mat_rd, tmp_rd;

	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[mat_wa] <= mat_wd;
		mat_rd <= mat_mem[mat_ra];
		if (tmp_we) tmp_mem[tmp_wa] <= sat_acc;
		tmp_rd <= tmp_mem[tmp_ra];
	end

	avte_pkg::cmd_t      cmd_q;
	logic                persp_q;
	logic signed [W-1:0] cz_q;
	logic [3:0]          elem_q;   // output element index (row,col)
	logic [2:0]          k_q;      // inner index, issue counter
	logic [2:0]          dr_q;     // drain counter
	logic signed [W-1:0] r_q [3];
	logic                div_sel_q;
	logic                err_q;
	logic                res_v_q;
	avte_pkg::res_t      res_q;

	logic                mac_en, mac_clr;
	logic signed [W:0]   mac_a;
	logic signed [W-1:0] mac_b;
	logic                is_vert;

	assign is_vert = (cmd_q.opcode == avte_pkg::OP_VERT);
	assign sat_acc = avte_pkg::sat(acc);

	// Operand for current k: matrix element read last cycle, paired with E or v.
	logic [1:0] k_d1;
	logic       iss_d1;
	logic       clr_d1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_d1 <= 1'b0;
			clr_d1 <= 1'b0;
			k_d1 <= '0;
		end else begin
			iss_d1 <= (st_q == ST_ISSUE);
			clr_d1 <= (st_q == ST_ISSUE) && (k_q == 3'd0);
			k_d1 <= k_q[1:0];
		end
	end

	always_comb begin
		mac_en = iss_d1;
		mac_clr = clr_d1;
		mac_b = mat_rd;
		if (is_vert) begin
			case (k_d1)
				2'd0: mac_a = {cmd_q.arg_a[W-1], cmd_q.arg_a};
				2'd1: mac_a = {cmd_q.arg_b[W-1], cmd_q.arg_b};
				2'd2: mac_a = {cmd_q.arg_c[W-1], cmd_q.arg_c};
				default: mac_a = (W+1)'(avte_pkg::ONE_Q);
			endcase
		end else begin
			mac_a = avte_pkg::elem(cmd_q.opcode, cmd_q.arg_a, cmd_q.arg_b,
				cmd_q.arg_c, elem_q[3:2], k_d1);
		end
	end

	avte_mac u_mac (
		.clk(clk), .arst_n(arst_n), .en(mac_en), .clr(mac_clr),
		.a(mac_a), .b(mac_b), .acc(acc)
	);

	// Matrix read address: vertex reads M[row][k], matmul reads M[k][col].
	always_comb begin
		tmp_ra = elem_q;
		if (is_vert) mat_ra = {elem_q[3:2], k_q[1:0]};
		else mat_ra = {k_q[1:0], elem_q[1:0]};
		mat_we = 1'b0;
		mat_wa = elem_q;
		mat_wd = tmp_rd;
		tmp_we = 1'b0;
		tmp_wa = elem_q;
		if (st_q == ST_INIT) begin
			mat_we = 1'b1;
			mat_wd = (elem_q[3:2] == elem_q[1:0]) ? avte_pkg::ONE_Q : '0;
		end else if (st_q == ST_COPY && k_q == 3'd1) begin
			mat_we = 1'b1;
		end else if (st_q == ST_WB && !is_vert) begin
			tmp_we = 1'b1;
		end
	end

	// Perspective divide; a zero divisor never starts the divider
	logic                div_start, div_done;
	logic signed [65:0]  quo;
	logic signed [64:0]  div_num;
	logic signed [33:0]  dnm;
	assign dnm = {{2{cz_q[W-1]}}, cz_q} - {{2{r_q[2][W-1]}}, r_q[2]};
	assign div_num = 65'(r_q[{1'b0, div_sel_q}]) * 65'(cz_q);
	assign div_start = (st_q == ST_DIV) && (dnm != '0);

	avte_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(dnm), .done(div_done), .quo(quo)
	);

	logic signed [W-1:0] quo_sat;
	always_comb begin
		if (quo > 66'(avte_pkg::SMAX)) quo_sat = avte_pkg::SMAX;
		else if (quo < 66'(avte_pkg::SMIN)) quo_sat = avte_pkg::SMIN;
		else quo_sat = quo[W-1:0];
	end

	assign cmd.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = res_v_q;
	assign res.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persp_q <= 1'b0;
			cz_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				avte_pkg::CFG_PERSP: persp_q <= cfg.data.data[0];
				avte_pkg::CFG_CZ:    cz_q <= cfg.data.data;
				default:             persp_q <= persp_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) cmd_q <= cmd.data;
		if (st_q == ST_WB && is_vert) r_q[elem_q[3:2]] <= sat_acc;
		if (div_done) r_q[{1'b0, div_sel_q}] <= quo_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			elem_q <= '0;
			k_q <= '0;
			dr_q <= '0;
			div_sel_q <= 1'b0;
			err_q <= 1'b0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			// ST_OUT reloads the register itself
			if (res.valid && res.ready && st_q != ST_OUT) res_v_q <= 1'b0;
			case (st_q)
				ST_INIT: begin
					elem_q <= elem_q + 4'd1;
					if (elem_q == 4'd15) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					elem_q <= '0;
					k_q <= '0;
					if (cmd.valid) begin
						case (cmd.data.opcode)
							avte_pkg::OP_IDENT: st_q <= ST_INIT;
							avte_pkg::OP_VERT,
							avte_pkg::OP_TRANS, avte_pkg::OP_SCALE,
							avte_pkg::OP_ROTX, avte_pkg::OP_ROTY,
							avte_pkg::OP_ROTZ: st_q <= ST_ISSUE;
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd3) begin
						st_q <= ST_DRAIN;
						dr_q <= '0;
					end
				end
				ST_DRAIN: begin
					// read, multiply, accumulate pipeline empties
					dr_q <= dr_q + 3'd1;
					if (dr_q == 3'd2) st_q <= ST_WB;
				end
				ST_WB: begin
					k_q <= '0;
					if (is_vert) begin
						if (elem_q[3:2] == 2'd2) begin
							err_q <= 1'b0;
							div_sel_q <= 1'b0;
							st_q <= persp_q ? ST_DIV : ST_OUT;
						end else begin
							elem_q <= elem_q + 4'd4;
							st_q <= ST_ISSUE;
						end
					end else if (elem_q == 4'd15) begin
						elem_q <= '0;
						st_q <= ST_COPY;
					end else begin
						elem_q <= elem_q + 4'd1;
						st_q <= ST_ISSUE;
					end
				end
				ST_COPY: begin
					// k_q toggles: read scratch, then write matrix
					if (k_q == 3'd0) k_q <= 3'd1;
					else begin
						k_q <= '0;
						elem_q <= elem_q + 4'd1;
						if (elem_q == 4'd15) st_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (dnm == '0) begin
						err_q <= 1'b1;
						st_q <= ST_OUT;
					end else st_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (div_sel_q) st_q <= ST_OUT;
						else begin
							div_sel_q <= 1'b1;
							st_q <= ST_DIV;
						end
					end
				end
				ST_OUT: begin
					if (!res_v_q || res.ready) begin
						res_v_q <= 1'b1;
						res_q.out_x <= err_q ? '0 : r_q[0];
						res_q.out_y <= err_q ? '0 : r_q[1];
						res_q.out_z <= r_q[2];
						res_q.divide_error <= err_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
